// File: src/assert_macros.svh
// Assertion macros shared by the RTL files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is held
`define NHP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked check that also holds during reset
`define NHP_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// File: src/nhp_pkg.sv
// Package: widths, codes and types of the nearest hit pair selector
`default_nettype none

package nhp_pkg;

    localparam int COORD_W    = 24;
    localparam int DIFF_W     = COORD_W + 1;
    localparam int CFG_INDEX_W = 1;

    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_PAIR  = 2'd1,
        OP_END   = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        KIND_DIFF   = 2'd0,
        KIND_FIRST  = 2'd1,
        KIND_SECOND = 2'd2
    } t_kind;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_AXIS   = 1'd0,
        REG_CUTOFF = 1'd1
    } t_reg;

    typedef struct packed {
        t_op                       op;
        logic signed [COORD_W-1:0] fx;
        logic signed [COORD_W-1:0] fy;
        logic signed [COORD_W-1:0] sx;
        logic signed [COORD_W-1:0] sy;
    } t_item;

    typedef struct packed {
        logic signed [DIFF_W-1:0]  dx;
        logic signed [DIFF_W-1:0]  dy;
        logic signed [COORD_W-1:0] fx;
        logic signed [COORD_W-1:0] fy;
        logic signed [COORD_W-1:0] sx;
        logic signed [COORD_W-1:0] sy;
    } t_best;

    // status from the result sequencer back to the search stage
    typedef struct packed {
        logic free;   // a new run of three results can be loaded this cycle
    } t_seq_stat;

endpackage

`default_nettype wire

// File: src/nhp_if.sv
// Channel interfaces: hit stream, result stream and register writes
`default_nettype none

interface nhp_in_if import nhp_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [1:0]                operation;
    logic signed [COORD_W-1:0] first_x;
    logic signed [COORD_W-1:0] first_y;
    logic signed [COORD_W-1:0] second_x;
    logic signed [COORD_W-1:0] second_y;

    modport source (output valid, operation, first_x, first_y, second_x, second_y,
                    input ready);
    modport sink   (input valid, operation, first_x, first_y, second_x, second_y,
                    output ready);
endinterface

interface nhp_out_if import nhp_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [1:0]               kind;
    logic signed [DIFF_W-1:0] out_x;
    logic signed [DIFF_W-1:0] out_y;
    logic                     last;

    modport source (output valid, kind, out_x, out_y, last, input ready);
    modport sink   (input valid, kind, out_x, out_y, last, output ready);
endinterface

interface nhp_cfg_if import nhp_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [COORD_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: src/nhp_in_stage.sv
// Input register stage for the hit stream
`default_nettype none

module nhp_in_stage import nhp_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    nhp_in_if.sink     i_in,
    input  wire logic  i_advance,
    output logic       o_valid,
    output t_item      o_item
);

    logic  r_valid;
    logic  n_valid;
    t_item r_item;
    t_item n_item;

    assign i_in.ready = !r_valid || i_advance;

    always_comb begin
        n_valid = r_valid && !i_advance;
        n_item  = r_item;
        if (i_in.valid && i_in.ready) begin
            n_valid   = 1'b1;
            n_item.op = t_op'(i_in.operation);
            n_item.fx = i_in.first_x;
            n_item.fy = i_in.first_y;
            n_item.sx = i_in.second_x;
            n_item.sy = i_in.second_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_item <= n_item;
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

`default_nettype wire

// File: src/nhp_best_track.sv
// Distance evaluation and best pair tracking
`default_nettype none

module nhp_best_track import nhp_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_item_valid,
    input  wire t_item              i_item,
    input  wire logic               i_axis,
    input  wire logic [COORD_W-1:0] i_cutoff,
    input  wire t_seq_stat          i_seq_stat,
    output logic                    o_advance,
    output logic                    o_emit,
    output t_best                   o_best
);

    logic [COORD_W-1:0]       r_dist;
    logic [COORD_W-1:0]       n_dist;
    t_best                    r_best;
    t_best                    n_best;
    logic signed [DIFF_W-1:0] w_dx;
    logic signed [DIFF_W-1:0] w_dy;
    logic signed [DIFF_W-1:0] w_comp;
    logic [DIFF_W-1:0]        w_abs;
    logic [COORD_W-1:0]       w_dist;
    logic                     w_better;
    logic                     w_emit_ok;
    logic                     w_is_end;

    assign w_dx   = {i_item.fx[COORD_W-1], i_item.fx} - {i_item.sx[COORD_W-1], i_item.sx};
    assign w_dy   = {i_item.fy[COORD_W-1], i_item.fy} - {i_item.sy[COORD_W-1], i_item.sy};
    assign w_comp = i_axis ? w_dy : w_dx;
    // magnitude of a difference of two coordinates always fits COORD_W bits
    assign w_abs  = w_comp[DIFF_W-1] ? DIFF_W'(~w_comp + 1'b1) : w_comp;
    assign w_dist = w_abs[COORD_W-1:0];

    assign w_better  = (w_dist != '0) && (w_dist < r_dist);
    assign w_emit_ok = r_dist < i_cutoff;
    assign w_is_end  = i_item.op == OP_END;

    // an emitting event end waits until the sequencer can take a new run
    assign o_advance = i_item_valid && !(w_is_end && w_emit_ok && !i_seq_stat.free);
    assign o_emit    = o_advance && w_is_end && w_emit_ok;

    always_comb begin
        n_dist = r_dist;
        n_best = r_best;
        if (o_advance) begin
            case (i_item.op)
                OP_START: begin
                    n_dist = i_cutoff;
                    n_best = '0;
                end
                OP_PAIR: begin
                    if (w_better) begin
                        n_dist    = w_dist;
                        n_best.dx = w_dx;
                        n_best.dy = w_dy;
                        n_best.fx = i_item.fx;
                        n_best.fy = i_item.fy;
                        n_best.sx = i_item.sx;
                        n_best.sy = i_item.sy;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dist <= '1;
            r_best <= '0;
        end else begin
            r_dist <= n_dist;
            r_best <= n_best;
        end
    end

    assign o_best = r_best;

endmodule

`default_nettype wire

// File: src/nhp_result_seq.sv
// Result sequencer: holds one best pair and sends it as three transactions
`default_nettype none

module nhp_result_seq import nhp_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_emit,
    input  wire t_best i_best,
    output t_seq_stat  o_stat,
    nhp_out_if.source  o_out
);

    // results still to send
    localparam logic [1:0] SLOT_NONE   = 2'd0;
    localparam logic [1:0] SLOT_SECOND = 2'd1;
    localparam logic [1:0] SLOT_FIRST  = 2'd2;
    localparam logic [1:0] SLOT_DIFF   = 2'd3;

    logic [1:0] r_cnt;
    logic [1:0] n_cnt;
    t_best      r_snap;
    t_best      n_snap;
    logic       w_take;

    assign w_take = o_out.valid && o_out.ready;

    assign o_stat.free = (r_cnt == SLOT_NONE) || (r_cnt == SLOT_SECOND && o_out.ready);

    always_comb begin
        n_cnt  = r_cnt;
        n_snap = r_snap;
        if (i_emit) begin
            n_cnt  = SLOT_DIFF;
            n_snap = i_best;
        end else if (w_take) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= SLOT_NONE;
        end else begin
            r_cnt <= n_cnt;
        end
        r_snap <= n_snap;
    end

    assign o_out.valid = r_cnt != SLOT_NONE;
    assign o_out.last  = r_cnt == SLOT_SECOND;

    always_comb begin
        case (r_cnt)
            SLOT_DIFF: begin
                o_out.kind  = KIND_DIFF;
                o_out.out_x = r_snap.dx;
                o_out.out_y = r_snap.dy;
            end
            SLOT_FIRST: begin
                o_out.kind  = KIND_FIRST;
                o_out.out_x = DIFF_W'(r_snap.fx);
                o_out.out_y = DIFF_W'(r_snap.fy);
            end
            default: begin
                o_out.kind  = KIND_SECOND;
                o_out.out_x = DIFF_W'(r_snap.sx);
                o_out.out_y = DIFF_W'(r_snap.sy);
            end
        endcase
    end

endmodule

`default_nettype wire

// File: src/nearest_hit_pair_select.sv
// Event end path: input register, then sequencer count and snapshot, then the output.
// Throughput: one input transaction per cycle; hit pairs never wait on the output
// themselves, but queue behind an event end that waits.
// An emitting event end holds the output for three result transactions; a second
// emitting event end waits in the input register until the last one is taken.
// Reset (i_rst_n low, synchronous): axis x, cutoff all ones, best distance all ones,
// no results pending.
`default_nettype none
`include "assert_macros.svh"

module nearest_hit_pair_select import nhp_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    nhp_in_if.sink    i_in,
    nhp_cfg_if.sink   i_cfg,
    nhp_out_if.source o_out
);

    // configuration registers, written by the user only while the block is idle; the block itself leaves this unchecked
    logic               r_axis;
    logic               n_axis;
    logic [COORD_W-1:0] r_cutoff;
    logic [COORD_W-1:0] n_cutoff;

    // stage wiring
    logic      w_in_valid;
    t_item     w_item;
    logic      w_advance;
    logic      w_emit;
    t_best     w_best;
    t_seq_stat w_stat;

    // assertion helpers
    logic      w_last_take;
    logic      w_stall;

    assign i_cfg.ready = 1'b1;

    always_comb begin
        n_axis   = r_axis;
        n_cutoff = r_cutoff;
        if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.index)
                REG_AXIS:   n_axis   = i_cfg.data[0];
                REG_CUTOFF: n_cutoff = i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_axis   <= 1'b0;
            r_cutoff <= '1;
        end else begin
            r_axis   <= n_axis;
            r_cutoff <= n_cutoff;
        end
    end

    // input register: one hit transaction per cycle, unless an event end waits on the output
    nhp_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_advance (w_advance),
        .o_valid   (w_in_valid),
        .o_item    (w_item)
    );

    // subtract, magnitude, compare against the running best
    nhp_best_track u_best_track (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (w_in_valid),
        .i_item       (w_item),
        .i_axis       (r_axis),
        .i_cutoff     (r_cutoff),
        .i_seq_stat   (w_stat),
        .o_advance    (w_advance),
        .o_emit       (w_emit),
        .o_best       (w_best)
    );

    // snapshot of the best pair, sent as difference, plane one, plane two
    nhp_result_seq u_result_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_emit  (w_emit),
        .i_best  (w_best),
        .o_stat  (w_stat),
        .o_out   (o_out)
    );

    assign w_last_take = o_out.valid && o_out.ready && o_out.last && !w_emit;
    assign w_stall     = w_in_valid && !w_advance;

    // a run is loaded only when the sequencer has room for it
    `NHP_ASSERT(a_emit_when_free, w_emit |-> w_stat.free, "result run loaded while busy")
    // after the last result is taken with no new run, the output goes quiet
    `NHP_ASSERT(a_idle_after_last, w_last_take |=> !o_out.valid, "output valid after last result")
    // a held item stays in the input register until it moves on
    `NHP_ASSERT(a_hold_stalled, w_stall |=> (w_in_valid && $stable(w_item)), "stalled item lost")

endmodule

`default_nettype wire
